### src/tpdt_pkg.sv
// Shared types, constants and the expiry test for the tick prescaler delay timer bank.
// Used by the prescaler, the top level and the port checker; no dependencies.
package tpdt_pkg;

    localparam int unsigned CNT_W       = 8;
    localparam int unsigned DIV_W       = 4;
    localparam logic [DIV_W-1:0] DIV_LAST = 4'd9;   // divide-by-ten prescalers run 0..9
    localparam int unsigned IDX_FIELD_W = 4;
    localparam int unsigned S_TDATA_W   = 16;
    localparam int unsigned M_TDATA_W   = 32;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_POLL = 1'b1
    } tpdt_op_t;

    typedef struct packed {
        logic [CNT_W-1:0] c1s;
        logic [CNT_W-1:0] c100ms;
        logic [CNT_W-1:0] c10ms;
    } tpdt_counts_t;

    // Wraparound expiry test: s = start, c = current 10 ms count, d = delay.
    function automatic logic delay_elapsed(input logic [CNT_W-1:0] s,
                                           input logic [CNT_W-1:0] c,
                                           input logic [CNT_W-1:0] d);
        logic [CNT_W:0] sum;
        logic           reached;
        logic           below;
        sum     = {1'b0, s} + {1'b0, d};
        reached = (c >= sum[CNT_W-1:0]);
        below   = (c < s);
        if (sum[CNT_W]) begin
            delay_elapsed = reached && below;
        end else begin
            delay_elapsed = reached || below;
        end
    endfunction

endpackage

### src/tick_prescaler_delay_timer_bank.sv
// Top level of the tick prescaler delay timer bank: stream ports, channel
// table and result register. Depends on tpdt_pkg and tpdt_prescaler.
//
// Takes one item per clock unless the result stalls and returns exactly one
// result per item in the cycle after it. A tick item (s_tuser = 0) advances the 1 ms
// prescaler cascade; a poll item (s_tuser = 1) arms an idle channel with the
// current 10 ms count or tests an armed one for expiry and disarms it when it
// fires. Polls of a channel at or above CHANNEL_COUNT report not-expired and
// change nothing. Every result carries the three counts after the item.
// A single result register separates the two sides: s_tready is high while
// that register is empty or being taken in the same cycle, so with m_tready
// held high the block sustains one item per cycle.
module tick_prescaler_delay_timer_bank
    import tpdt_pkg::*;
#(
    parameter int unsigned CHANNEL_COUNT = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [3:0] channel_index, [11:4] delay_ticks
    input  logic                 s_tuser,   // [0] opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [0] expired, [8:1] count_10ms,
                                            // [16:9] count_100ms, [24:17] count_1s
);

    localparam int unsigned IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    logic                   armed_reg [CHANNEL_COUNT];
    logic [CNT_W-1:0]       start_reg [CHANNEL_COUNT];
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    logic                   accept;
    tpdt_op_t               op;
    logic [IDX_FIELD_W-1:0] chan_idx;
    logic [CNT_W-1:0]       delay;
    logic [IDX_W-1:0]       slot;
    logic                   in_range;
    logic                   is_poll;
    logic                   slot_armed;
    logic [CNT_W-1:0]       slot_start;
    logic                   fired;
    tpdt_counts_t           counts, counts_next;

    assign s_tready = aresetn && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign op       = tpdt_op_t'(s_tuser);
    assign chan_idx = s_tdata[IDX_FIELD_W-1:0];
    assign delay    = s_tdata[IDX_FIELD_W +: CNT_W];
    assign slot     = IDX_W'(chan_idx);
    assign in_range = ({1'b0, chan_idx} < (IDX_FIELD_W+1)'(CHANNEL_COUNT));
    assign is_poll  = accept && (op == OP_POLL) && in_range;

    tpdt_prescaler u_prescaler (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick        (accept && (op == OP_TICK)),
        .counts      (counts),
        .counts_next (counts_next)
    );

    always_comb begin
        slot_armed = 1'b0;
        slot_start = '0;
        if (in_range) begin
            slot_armed = armed_reg[slot];
            slot_start = start_reg[slot];
        end
        fired = is_poll && slot_armed && delay_elapsed(slot_start, counts.c10ms, delay);
    end

    // Arm on a poll of an idle channel, disarm when it fires.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                armed_reg[i] <= 1'b0;
            end
        end else if (is_poll) begin
            if (!slot_armed) begin
                armed_reg[slot] <= 1'b1;
            end else if (fired) begin
                armed_reg[slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (is_poll && !slot_armed) begin
            start_reg[slot] <= counts.c10ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= M_TDATA_W'({counts_next.c1s, counts_next.c100ms,
                                       counts_next.c10ms, fired});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### src/tpdt_prescaler.sv
// Millisecond prescaler cascade: three divide-by-ten stages feeding wrapping
// 10 ms, 100 ms and 1 s counters. Depends on tpdt_pkg.
module tpdt_prescaler
    import tpdt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         tick,        // advance by one millisecond
    output tpdt_counts_t counts,      // current counts
    output tpdt_counts_t counts_next  // counts after this cycle's tick, if any
);

    logic [DIV_W-1:0] ms_div_reg, ms_div_next;
    logic [DIV_W-1:0] tens_div_reg, tens_div_next;
    logic [DIV_W-1:0] hund_div_reg, hund_div_next;
    tpdt_counts_t     counts_reg, counts_next_int;

    logic wrap_ms, wrap_tens, wrap_hund;

    always_comb begin
        wrap_ms   = tick && (ms_div_reg == DIV_LAST);
        wrap_tens = wrap_ms && (tens_div_reg == DIV_LAST);
        wrap_hund = wrap_tens && (hund_div_reg == DIV_LAST);

        ms_div_next     = ms_div_reg;
        tens_div_next   = tens_div_reg;
        hund_div_next   = hund_div_reg;
        counts_next_int = counts_reg;

        if (tick) begin
            ms_div_next = wrap_ms ? '0 : ms_div_reg + DIV_W'(1);
        end
        if (wrap_ms) begin
            counts_next_int.c10ms = counts_reg.c10ms + CNT_W'(1);
            tens_div_next = wrap_tens ? '0 : tens_div_reg + DIV_W'(1);
        end
        if (wrap_tens) begin
            counts_next_int.c100ms = counts_reg.c100ms + CNT_W'(1);
            hund_div_next = wrap_hund ? '0 : hund_div_reg + DIV_W'(1);
        end
        if (wrap_hund) begin
            counts_next_int.c1s = counts_reg.c1s + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_div_reg   <= '0;
            tens_div_reg <= '0;
            hund_div_reg <= '0;
            counts_reg   <= '0;
        end else begin
            ms_div_reg   <= ms_div_next;
            tens_div_reg <= tens_div_next;
            hund_div_reg <= hund_div_next;
            counts_reg   <= counts_next_int;
        end
    end

    assign counts      = counts_reg;
    assign counts_next = counts_next_int;

endmodule

### src/tpdt_checker.sv
// Port-level checker for the tick prescaler delay timer bank, bound to the top
// level. Depends on tpdt_pkg.
module tpdt_checker
    import tpdt_pkg::*;
#(
    parameter int unsigned CHANNEL_COUNT = 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic in_acc;
    logic out_acc;
    logic out_of_range;

    assign in_acc       = s_tvalid && s_tready;
    assign out_acc      = m_tvalid && m_tready;
    assign out_of_range = ({1'b0, s_tdata[IDX_FIELD_W-1:0]} >=
                           (IDX_FIELD_W+1)'(CHANNEL_COUNT));

    // Hold a stalled result.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> m_tvalid)
        else $error("accepted item produced no result");

    a_tick_not_expired: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && (s_tuser == OP_TICK) |=> m_tdata[0] == 1'b0)
        else $error("tick item reported expiry");

    a_bad_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && (s_tuser == OP_POLL) && out_of_range |=> m_tdata[0] == 1'b0)
        else $error("poll of missing channel reported expiry");

    // A poll leaves the counts as the previous result showed them.
    a_poll_keeps_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && in_acc && (s_tuser == OP_POLL)
        |=> m_tdata[24:1] == $past(m_tdata[24:1]))
        else $error("poll changed the counts");

endmodule

bind tick_prescaler_delay_timer_bank tpdt_checker #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
) u_tpdt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### sim/tb_tick_prescaler_delay_timer_bank.sv
// Self-checking bench for tick_prescaler_delay_timer_bank: a directed table, then random
// ticks and channel polls, checked against an in-bench timer predictor.
// Depends on tpdt_pkg and the block's RTL only.
module tb_tick_prescaler_delay_timer_bank;
    import tpdt_pkg::*;

    localparam int unsigned N_CHAN      = 8;
    localparam int unsigned RAND_ITEMS  = 1480;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned N_ROWS      = 22;

    typedef struct packed {
        logic             fired;
        logic [CNT_W-1:0] t10;
        logic [CNT_W-1:0] t100;
        logic [CNT_W-1:0] t1s;
    } timer_result_t;

    typedef struct packed {
        tpdt_op_t      op;
        logic [3:0]    idx;
        logic [7:0]    dly;
        logic          typed;
        timer_result_t want;
    } stim_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [3:0] channel_index, [11:4] delay_ticks
    logic                 s_tuser  = 1'b0; // [0] opcode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [0] expired, [8:1] count_10ms,
                                           // [16:9] count_100ms, [24:17] count_1s

    // predictor state
    logic [DIV_W-1:0] ms_div, tens_div, hund_div;
    logic [CNT_W-1:0] cnt10, cnt100, cnt1s;
    logic             armed [16];
    logic [CNT_W-1:0] start_cnt [16];

    timer_result_t expected_q[$];
    timer_result_t got_r, want_r;
    stim_row_t     stim_table [N_ROWS];
    int unsigned   err_count   = 0;
    int unsigned   cycle_cnt   = 0;
    bit            src_gaps_on = 1'b1;
    bit            snk_gaps_on = 1'b1;
    bit            hold_req    = 1'b0;

    tick_prescaler_delay_timer_bank #(
        .CHANNEL_COUNT(N_CHAN)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void clear_timer_bank();
        ms_div   = '0;
        tens_div = '0;
        hund_div = '0;
        cnt10    = '0;
        cnt100   = '0;
        cnt1s    = '0;
        for (int i = 0; i < 16; i++) begin
            armed[i]     = 1'b0;
            start_cnt[i] = '0;
        end
    endfunction

    // Apply one tick or poll to the predictor state; return the result it causes.
    function automatic timer_result_t step_timer_bank(input tpdt_op_t op,
                                                      input logic [3:0] idx,
                                                      input logic [7:0] dly);
        timer_result_t r;
        logic [CNT_W:0] due;
        logic           hit;
        r.fired = 1'b0;
        if (op == OP_TICK) begin
            if (ms_div != DIV_LAST) begin
                ms_div = ms_div + 1'b1;
            end else begin
                ms_div = '0;
                cnt10  = cnt10 + 1'b1;
                if (tens_div != DIV_LAST) begin
                    tens_div = tens_div + 1'b1;
                end else begin
                    tens_div = '0;
                    cnt100   = cnt100 + 1'b1;
                    if (hund_div != DIV_LAST) begin
                        hund_div = hund_div + 1'b1;
                    end else begin
                        hund_div = '0;
                        cnt1s    = cnt1s + 1'b1;
                    end
                end
            end
        end else if (idx < N_CHAN) begin
            if (!armed[idx]) begin
                start_cnt[idx] = cnt10;
                armed[idx]     = 1'b1;
            end else begin
                due = {1'b0, start_cnt[idx]} + {1'b0, dly};
                // past 255 the deadline wraps: fire only once the count has wrapped too
                if (due[CNT_W])
                    hit = (cnt10 >= due[CNT_W-1:0]) && (cnt10 < start_cnt[idx]);
                else
                    hit = (cnt10 >= due[CNT_W-1:0]) || (cnt10 < start_cnt[idx]);
                if (hit) begin
                    armed[idx] = 1'b0;
                    r.fired    = 1'b1;
                end
            end
        end
        r.t10  = cnt10;
        r.t100 = cnt100;
        r.t1s  = cnt1s;
        return r;
    endfunction

    task automatic offer_item(input tpdt_op_t op, input logic [3:0] idx, input logic [7:0] dly,
                              input logic typed, input timer_result_t typed_want);
        timer_result_t predicted;
        @(negedge aclk);
        while (src_gaps_on && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W-12){1'b0}}, dly, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = step_timer_bank(op, idx, dly);
        expected_q.push_back(typed ? typed_want : predicted);
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_r.fired = m_tdata[0];
            got_r.t10   = m_tdata[8:1];
            got_r.t100  = m_tdata[16:9];
            got_r.t1s   = m_tdata[24:17];
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %h", $time, m_tdata);
                err_count++;
            end else begin
                want_r = expected_q.pop_front();
                check_field("expired", want_r.fired, got_r.fired);
                check_field("count_10ms", want_r.t10, got_r.t10);
                check_field("count_100ms", want_r.t100, got_r.t100);
                check_field("count_1s", want_r.t1s, got_r.t1s);
            end
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= !(snk_gaps_on && $urandom_range(99) < 10);
        end
    end

    initial begin
        tpdt_op_t      r_op;
        logic [3:0]    r_idx;
        logic [7:0]    r_dly;
        int unsigned   pick;
        timer_result_t none;

        none = '0;
        stim_table = '{
            '{OP_TICK, 4'd0,  8'd0,   1'b1, '{1'b0, 8'd0, 8'd0, 8'd0}},
            '{OP_POLL, 4'd15, 8'd255, 1'b1, '{1'b0, 8'd0, 8'd0, 8'd0}}, // top index, out of range
            '{OP_POLL, 4'd8,  8'd0,   1'b1, '{1'b0, 8'd0, 8'd0, 8'd0}}, // first index out of range
            '{OP_POLL, 4'd0,  8'd255, 1'b1, '{1'b0, 8'd0, 8'd0, 8'd0}}, // arm, delay ignored
            '{OP_POLL, 4'd0,  8'd0,   1'b0, '0},                         // zero delay fires
            '{OP_POLL, 4'd7,  8'd0,   1'b1, '{1'b0, 8'd0, 8'd0, 8'd0}}, // arm last channel
            '{OP_POLL, 4'd7,  8'd255, 1'b0, '0},
            '{OP_TICK, 4'd15, 8'd255, 1'b0, '0},                         // fields ignored on ticks
            '{OP_TICK, 4'd15, 8'd255, 1'b0, '0},
            '{OP_TICK, 4'd15, 8'd255, 1'b0, '0},
            '{OP_TICK, 4'd15, 8'd255, 1'b0, '0},
            '{OP_TICK, 4'd15, 8'd255, 1'b0, '0},
            '{OP_TICK, 4'd15, 8'd255, 1'b0, '0},
            '{OP_TICK, 4'd15, 8'd255, 1'b0, '0},
            '{OP_TICK, 4'd15, 8'd255, 1'b0, '0},
            '{OP_TICK, 4'd15, 8'd255, 1'b0, '0},                         // tenth tick: 10 ms step
            '{OP_POLL, 4'd7,  8'd1,   1'b0, '0},
            '{OP_POLL, 4'd3,  8'd128, 1'b0, '0},
            '{OP_POLL, 4'd3,  8'd255, 1'b0, '0},                         // deadline wraps past 255
            '{OP_POLL, 4'd5,  8'd170, 1'b0, '0},
            '{OP_POLL, 4'd5,  8'd85,  1'b0, '0},
            '{OP_TICK, 4'd10, 8'd85,  1'b0, '0}
        };

        clear_timer_bank();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < N_ROWS; k++)
            offer_item(stim_table[k].op, stim_table[k].idx, stim_table[k].dly,
                       stim_table[k].typed, stim_table[k].want);

        // Mostly ticks, so the 10 ms count moves well past the start of many armed channels.
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k == 300)
                hold_req = 1'b1;
            if (k == 700)
                drain_results();
            src_gaps_on = !(k >= 1000 && k < 1300);
            snk_gaps_on = !(k >= 1000 && k < 1300);
            r_op  = ($urandom_range(99) < 90) ? OP_TICK : OP_POLL;
            r_idx = ($urandom_range(99) < 85) ? 4'($urandom_range(N_CHAN - 1))
                                              : 4'($urandom_range(15));
            pick  = $urandom_range(99);
            if (pick < 50)
                r_dly = 8'($urandom_range(15));
            else if (pick < 60)
                r_dly = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
            else
                r_dly = 8'($urandom_range(255));
            offer_item(r_op, r_idx, r_dly, 1'b0, none);
        end

        drain_results();
        repeat (4) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
